// File: rtl/core/chs_pkg.sv
package chs_pkg;

    localparam int BUCKETS          = 16;
    localparam int SLOTS_PER_BUCKET = 8;
    localparam int KEY_W            = 32;

    localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SLOT_W   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int CNT_W    = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int DEPTH    = BUCKETS * SLOTS_PER_BUCKET;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_DELETE = 2'd2
    } command_t;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [KEY_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic found;
        logic dropped;
    } result_t;

    function automatic logic [ADDR_W-1:0] slot_addr(
        input logic [BUCKET_W-1:0] bucket,
        input logic [SLOT_W-1:0]   slot
    );
        return ADDR_W'(ADDR_W'(bucket) * ADDR_W'(SLOTS_PER_BUCKET)) + ADDR_W'(slot);
    endfunction

endpackage

// File: rtl/core/chs_ram.sv
module chs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/chained_hash_set_top.sv
// Hash set of signed 32-bit keys, bucketed on the key's low bits, each bucket a
// bounded chain of slots in one RAM. A transaction is accepted when start is high
// and busy is low; busy then stays high while a small sequencer walks the chain,
// one slot compare per cycle through the single RAM read port. A delete of a
// present key also reads the last slot of the chain and writes it into the freed
// one. The result appears for exactly one cycle with result_valid, in the cycle
// busy falls; it cannot be stalled and must be taken then. A new transaction may
// be started in that same cycle.
module chained_hash_set_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  chs_pkg::request_t request,
    output logic              busy,
    output logic              result_valid,
    output chs_pkg::result_t  result
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_ACT  = 4'b0100,
        S_MOVE = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [1:0]                      cmd_reg, cmd_next;
    logic [chs_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [chs_pkg::BUCKET_W-1:0]    bucket_reg, bucket_next;
    logic [chs_pkg::CNT_W-1:0]       n_reg, n_next;
    logic [chs_pkg::CNT_W-1:0]       issue_reg, issue_next;
    logic                            pend_reg, pend_next;
    logic [chs_pkg::SLOT_W-1:0]      pend_idx_reg, pend_idx_next;
    logic                            found_reg, found_next;
    logic [chs_pkg::SLOT_W-1:0]      pos_reg, pos_next;
    chs_pkg::result_t                result_reg, result_next;
    logic                            result_valid_reg, result_valid_next;
    logic [chs_pkg::CNT_W-1:0]       chain_len_reg [chs_pkg::BUCKETS];

    logic                            len_we;
    logic [chs_pkg::CNT_W-1:0]       len_wdata;
    logic                            ram_we;
    logic [chs_pkg::ADDR_W-1:0]      ram_waddr;
    logic [chs_pkg::KEY_W-1:0]       ram_wdata;
    logic                            ram_re;
    logic [chs_pkg::ADDR_W-1:0]      ram_raddr;
    logic [chs_pkg::KEY_W-1:0]       ram_rdata;
    logic                            match;
    logic [chs_pkg::BUCKET_W-1:0]    req_bucket;

    assign req_bucket = request.value[chs_pkg::BUCKET_W-1:0];
    assign match      = pend_reg && (ram_rdata == key_reg);

    chs_ram #(
        .WIDTH (chs_pkg::KEY_W),
        .DEPTH (chs_pkg::DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        key_next          = key_reg;
        bucket_next       = bucket_reg;
        n_next            = n_reg;
        issue_next        = issue_reg;
        pend_next         = pend_reg;
        pend_idx_next     = pend_idx_reg;
        found_next        = found_reg;
        pos_next          = pos_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        len_we            = 1'b0;
        len_wdata         = n_reg;
        ram_we            = 1'b0;
        ram_waddr         = chs_pkg::slot_addr(bucket_reg, pos_reg);
        ram_wdata         = key_reg;
        ram_re            = 1'b0;
        ram_raddr         = chs_pkg::slot_addr(bucket_reg, chs_pkg::SLOT_W'(issue_reg));

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = request.command;
                    key_next    = request.value;
                    bucket_next = req_bucket;
                    n_next      = chain_len_reg[req_bucket];
                    issue_next  = '0;
                    pend_next   = 1'b0;
                    found_next  = 1'b0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    found_next = 1'b1;
                    pos_next   = pend_idx_reg;
                    pend_next  = 1'b0;
                    state_next = S_ACT;
                end
                else if (issue_reg < n_reg)
                begin
                    ram_re        = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = chs_pkg::SLOT_W'(issue_reg);
                    issue_next    = issue_reg + chs_pkg::CNT_W'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                state_next        = S_IDLE;
                result_valid_next = 1'b1;
                result_next       = '{found: found_reg, dropped: 1'b0};
                case (cmd_reg)
                    chs_pkg::CMD_INSERT:
                    begin
                        if (!found_reg)
                        begin
                            if (n_reg < chs_pkg::CNT_W'(chs_pkg::SLOTS_PER_BUCKET))
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = chs_pkg::slot_addr(bucket_reg,
                                                               chs_pkg::SLOT_W'(n_reg));
                                len_we    = 1'b1;
                                len_wdata = n_reg + chs_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                result_next.dropped = 1'b1;
                            end
                        end
                    end
                    chs_pkg::CMD_DELETE:
                    begin
                        if (found_reg)
                        begin
                            // fetch the tail entry, then move it into the freed slot
                            ram_re            = 1'b1;
                            ram_raddr         = chs_pkg::slot_addr(bucket_reg,
                                                    chs_pkg::SLOT_W'(n_reg - chs_pkg::CNT_W'(1)));
                            state_next        = S_MOVE;
                            result_valid_next = 1'b0;
                            result_next       = result_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_MOVE:
            begin
                ram_we            = 1'b1;
                ram_wdata         = ram_rdata;
                len_we            = 1'b1;
                len_wdata         = n_reg - chs_pkg::CNT_W'(1);
                result_valid_next = 1'b1;
                result_next       = '{found: 1'b1, dropped: 1'b0};
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        bucket_reg   <= bucket_next;
        n_reg        <= n_next;
        issue_reg    <= issue_next;
        pend_idx_reg <= pend_idx_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
        result_reg   <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < chs_pkg::BUCKETS; i++)
            begin
                chain_len_reg[i] <= '0;
            end
        end
        else if (len_we)
        begin
            chain_len_reg[bucket_reg] <= len_wdata;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: rtl/core/chs_checker.sv
module chs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             result_valid,
    input chs_pkg::result_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($past(busy) && !busy))
        else $error("result without a finished transaction");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_found_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.found && result.dropped))
        else $error("found and dropped both set");

endmodule

bind chained_hash_set_top chs_checker u_chs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
